@@ hw/rtl/contiguous_slot_run_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous slot run allocator
// Both macros sample on the rising edge of clk and are held off during reset.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_SLOT_RUN_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SLOT_RUN_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/csra_pkg.sv @@
// ----------------------------------------------------------------------------
// csra_pkg
// Types, codes and default sizes shared by the slot run allocator files.
// ----------------------------------------------------------------------------
package csra_pkg;

    // Storage is sized for the largest table the slot fields can address.
    localparam int SLOT_DEPTH = 4096;
    localparam int SLOT_AW    = 12;
    localparam int CNT_W      = 13;

    localparam int DEF_SLOTS_PER_GROUP = 1024;
    localparam int DEF_GROUP_COUNT     = 4;
    localparam int DEF_SEARCH_ORIGIN   = 0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        SLOT_CLEAR  = 2'd0,
        SLOT_MAPPED = 2'd1,
        SLOT_GUARD  = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic               func;
        logic [SLOT_AW-1:0] run_length;
        logic [SLOT_AW-1:0] start_slot;
    } csra_in_t;

    typedef struct packed {
        logic               ok;
        logic [SLOT_AW-1:0] result_slot;
        logic [CNT_W-1:0]   freed_count;
    } csra_out_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        slot_state_t        data;
    } csra_wr_t;

endpackage

@@ hw/rtl/csra_slot_ram.sv @@
// ----------------------------------------------------------------------------
// csra_slot_ram
// Slot state table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module csra_slot_ram
(
    input  logic                          clk,
    input  csra_pkg::csra_wr_t            wr,
    input  logic                          rd_en,
    input  logic [csra_pkg::SLOT_AW-1:0]  rd_addr,
    output csra_pkg::slot_state_t         rd_data
);

    csra_pkg::slot_state_t mem [csra_pkg::SLOT_DEPTH];
    csra_pkg::slot_state_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/contiguous_slot_run_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator - first fit slot run allocator with guard slot
// One request at a time. Reset clears min(SLOTS_PER_GROUP*GROUP_COUNT, 4096) slots.
// ----------------------------------------------------------------------------
//
// The slot table lives in a synchronous RAM (csra_slot_ram). One request is
// worked on at a time. The controller issues one table read per cycle and
// judges the data in the next cycle, so a scan or a free walk advances one slot
// per cycle. The reads run ahead of the judging by one slot; when a scan
// finds its run or a walk meets its guard, the read already in flight is
// simply dropped.
//
// Allocation looks for run_length + 1 clear slots in a row, first from the
// slot after the search origin up to the end of the table, then from slot 0
// up to the end of the origin's group. The last slot of the run becomes a
// guard and the slots before it become mapped, written one per cycle.
//
// A free clears slots upward from start_slot, and stops after clearing a
// guard or after the last slot of the table. A free that starts beyond the
// table frees nothing and goes straight to the response.
//
// Reads and writes never touch the same entry in the same cycle: a scan only
// reads, marking only writes, and the free walk writes the slot it judged
// while it reads the next one. The states follow one another, so a write is
// always in the table before any later read of that entry.
//
// The finished result goes into an output register, so the block can take
// the next request while that result still waits for its transfer.
// ----------------------------------------------------------------------------
`include "contiguous_slot_run_allocator_macros.svh"

module contiguous_slot_run_allocator
#(
    parameter int SLOTS_PER_GROUP = csra_pkg::DEF_SLOTS_PER_GROUP,
    parameter int GROUP_COUNT     = csra_pkg::DEF_GROUP_COUNT,
    parameter int SEARCH_ORIGIN   = csra_pkg::DEF_SEARCH_ORIGIN
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                request_valid,
    output logic                request_stall,
    input  csra_pkg::csra_in_t  request,

    output logic                response_valid,
    input  logic                response_stall,
    output csra_pkg::csra_out_t response
);

    localparam int AW = csra_pkg::SLOT_AW;
    localparam int CW = csra_pkg::CNT_W;

    // Table size and scan bounds, all settled at elaboration.
    localparam int TOTAL_I = (SLOTS_PER_GROUP * GROUP_COUNT > csra_pkg::SLOT_DEPTH) ?
                             csra_pkg::SLOT_DEPTH : SLOTS_PER_GROUP * GROUP_COUNT;
    localparam int FIRST_FROM_I = (SEARCH_ORIGIN + 1 < TOTAL_I) ? SEARCH_ORIGIN + 1 : TOTAL_I;
    localparam int WRAP_END_I   = (SEARCH_ORIGIN / SLOTS_PER_GROUP + 1) * SLOTS_PER_GROUP;
    localparam int SECOND_TO_I  = (WRAP_END_I < TOTAL_I) ? WRAP_END_I : TOTAL_I;

    localparam logic [CW-1:0] TOTAL      = CW'(TOTAL_I);
    localparam logic [CW-1:0] FIRST_FROM = CW'(FIRST_FROM_I);
    localparam logic [CW-1:0] SECOND_TO  = CW'(SECOND_TO_I);
    localparam logic [CW-1:0] LAST_CNT   = CW'(TOTAL_I - 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(TOTAL_I - 1);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2,
        ST_MARK,
        ST_FREE,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;     // next slot to read
    logic [CW-1:0]       end_reg, end_next;           // scan stops before this slot
    logic                p_vld_reg, p_vld_next;       // read data arrives this cycle
    logic [AW-1:0]       p_addr_reg, p_addr_next;     // slot of that read data
    logic [CW-1:0]       run_reg, run_next;           // clear slots in a row so far
    logic [CW-1:0]       need_reg, need_next;         // clear slots the run needs
    logic [AW-1:0]       n_reg, n_next;               // requested run length
    logic [AW-1:0]       guard_reg, guard_next;       // guard slot of the found run
    logic [CW-1:0]       wr_ptr_reg, wr_ptr_next;     // clearing pass and marking pointer
    logic [CW-1:0]       freed_reg, freed_next;
    logic                ok_reg, ok_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic                response_valid_reg, response_valid_next;
    csra_pkg::csra_out_t response_reg, response_next;

    csra_pkg::csra_wr_t    wr;
    logic                  rd_en;
    csra_pkg::slot_state_t rd_data;
    logic                  issue;
    logic                  load;

    csra_slot_ram u_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign issue = (rd_ptr_reg < end_reg);

    // The output register takes a new result when it is empty or being drained.
    assign load = (state_reg == ST_RESP) && (!response_valid_reg || !response_stall);

    always_comb
    begin
        state_next          = state_reg;
        rd_ptr_next         = rd_ptr_reg;
        end_next            = end_reg;
        p_vld_next          = 1'b0;
        p_addr_next         = p_addr_reg;
        run_next            = run_reg;
        need_next           = need_reg;
        n_next              = n_reg;
        guard_next          = guard_reg;
        wr_ptr_next         = wr_ptr_reg;
        freed_next          = freed_reg;
        ok_next             = ok_reg;
        slot_next           = slot_reg;
        response_valid_next = response_valid_reg;
        response_next       = response_reg;
        rd_en               = 1'b0;
        wr.en               = 1'b0;
        wr.addr             = wr_ptr_reg[AW-1:0];
        wr.data             = csra_pkg::SLOT_CLEAR;

        if (response_valid_reg && !response_stall)
        begin
            response_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                wr.en = 1'b1;
                if (wr_ptr_reg == LAST_CNT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                if (request_valid)
                begin
                    run_next  = '0;
                    freed_next = '0;
                    ok_next   = 1'b0;
                    slot_next = '0;
                    end_next  = TOTAL;
                    if (request.func == csra_pkg::FUNC_ALLOC)
                    begin
                        n_next      = request.run_length;
                        need_next   = {1'b0, request.run_length} + CW'(1);
                        rd_ptr_next = FIRST_FROM;
                        state_next  = ST_SCAN1;
                    end
                    else if ({1'b0, request.start_slot} < TOTAL)
                    begin
                        rd_ptr_next = {1'b0, request.start_slot};
                        state_next  = ST_FREE;
                    end
                    else
                    begin
                        // A start beyond the table frees nothing.
                        state_next = ST_RESP;
                    end
                end
            end

            ST_SCAN1, ST_SCAN2:
            begin
                rd_en       = issue;
                p_vld_next  = issue;
                p_addr_next = rd_ptr_reg[AW-1:0];
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end

                if (p_vld_reg)
                begin
                    if (rd_data == csra_pkg::SLOT_CLEAR)
                    begin
                        if ((run_reg + CW'(1)) >= need_reg)
                        begin
                            guard_next  = p_addr_reg;
                            wr_ptr_next = {1'b0, p_addr_reg - n_reg};
                            p_vld_next  = 1'b0;
                            state_next  = ST_MARK;
                        end
                        else
                        begin
                            run_next = run_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (!issue)
                begin
                    if (state_reg == ST_SCAN1)
                    begin
                        // Nothing in the upper part: rescan from slot 0.
                        rd_ptr_next = '0;
                        end_next    = SECOND_TO;
                        run_next    = '0;
                        state_next  = ST_SCAN2;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_MARK:
            begin
                wr.en = 1'b1;
                if (wr_ptr_reg[AW-1:0] == guard_reg)
                begin
                    wr.data    = csra_pkg::SLOT_GUARD;
                    ok_next    = 1'b1;
                    slot_next  = guard_reg - n_reg;
                    state_next = ST_RESP;
                end
                else
                begin
                    wr.data     = csra_pkg::SLOT_MAPPED;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
            end

            ST_FREE:
            begin
                rd_en       = issue;
                p_vld_next  = issue;
                p_addr_next = rd_ptr_reg[AW-1:0];
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end

                if (p_vld_reg)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = p_addr_reg;
                    freed_next = freed_reg + CW'(1);
                    if (rd_data == csra_pkg::SLOT_GUARD)
                    begin
                        ok_next    = 1'b1;
                        p_vld_next = 1'b0;
                        state_next = ST_RESP;
                    end
                    else if (p_addr_reg == LAST_SLOT)
                    begin
                        // Walked off the end of the table without a guard.
                        p_vld_next = 1'b0;
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (load)
                begin
                    response_valid_next       = 1'b1;
                    response_next.ok          = ok_reg;
                    response_next.result_slot = slot_reg;
                    response_next.freed_count = freed_reg;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLR;
            rd_ptr_reg         <= '0;
            end_reg            <= '0;
            p_vld_reg          <= 1'b0;
            wr_ptr_reg         <= '0;
            response_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            rd_ptr_reg         <= rd_ptr_next;
            end_reg            <= end_next;
            p_vld_reg          <= p_vld_next;
            wr_ptr_reg         <= wr_ptr_next;
            response_valid_reg <= response_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg   <= p_addr_next;
        run_reg      <= run_next;
        need_reg     <= need_next;
        n_reg        <= n_next;
        guard_reg    <= guard_next;
        freed_reg    <= freed_next;
        ok_reg       <= ok_next;
        slot_reg     <= slot_next;
        response_reg <= response_next;
    end

    assign request_stall  = (state_reg != ST_IDLE);
    assign response_valid = response_valid_reg;
    assign response       = response_reg;

    // Marking never runs past the guard slot of the run it found.
    `CSRA_ASSERT_SAME(a_mark_bound, state_reg == ST_MARK, wr_ptr_reg[AW-1:0] <= guard_reg, "mark past guard")
    // A scan leaves as soon as the run is long enough.
    `CSRA_ASSERT_SAME(a_run_bound, state_reg == ST_SCAN1 || state_reg == ST_SCAN2, run_reg < need_reg, "run over need")
    // The free walk only judges slots inside the table.
    `CSRA_ASSERT_SAME(a_free_bound, state_reg == ST_FREE && p_vld_reg, {1'b0, p_addr_reg} < TOTAL, "free left table")
    // A finished request always reaches the output register.
    `CSRA_ASSERT_NEXT(a_resp_load, load, response_valid_reg && state_reg == ST_IDLE, "result not loaded")

endmodule

@@ tb/contiguous_slot_run_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot run allocator testbench
// Drives allocate and free requests into the allocator, keeps a mirror of the
// slot table to predict every response, and compares each response transfer
// field by field. Directed cases come first, then mostly well-formed random
// traffic with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_tb;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 118;
    // The slowest single request is a full-table allocate: about 4095 slots
    // scanned plus 4095 slots marked. The reset clearing pass also walks the
    // whole table before the first request can go in. The limit covers that
    // several times over, stalls included.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 64;

    localparam int PRODUCT_SLOTS = csra_pkg::DEF_SLOTS_PER_GROUP * csra_pkg::DEF_GROUP_COUNT;
    localparam int TABLE_SLOTS   = (PRODUCT_SLOTS > csra_pkg::SLOT_DEPTH) ?
                                   csra_pkg::SLOT_DEPTH : PRODUCT_SLOTS;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HOLD
    } stall_mode_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                request_valid  = 1'b0;
    logic                request_stall;
    csra_pkg::csra_in_t  request        = '0;
    logic                response_valid;
    logic                response_stall = 1'b0;
    csra_pkg::csra_out_t response;

    // Mirror of the slot table and the responses still owed by the block.
    csra_pkg::slot_state_t slot_mirror [csra_pkg::SLOT_DEPTH];
    csra_pkg::csra_out_t   pending_responses [$];
    // First slots of runs that are believed to be live, used to build
    // well-formed free requests.
    int          live_runs [$];

    int          error_count  = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    stall_mode_t stall_mode   = STALL_NONE;
    int          stall_left   = 0;

    contiguous_slot_run_allocator
    #(
        .SLOTS_PER_GROUP (csra_pkg::DEF_SLOTS_PER_GROUP),
        .GROUP_COUNT     (csra_pkg::DEF_GROUP_COUNT),
        .SEARCH_ORIGIN   (csra_pkg::DEF_SEARCH_ORIGIN)
    )
    u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .request        (request),
        .response_valid (response_valid),
        .response_stall (response_stall),
        .response       (response)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Returns the last slot of the first run of need clear slots found in
    // [from_slot, to_slot), or -1 when there is no such run. Any slot that is
    // not clear breaks the run.
    function automatic int last_of_clear_run(input int from_slot, input int to_slot,
                                             input int need);
        int run_len;
        int s;
        run_len = 0;
        for (s = from_slot; s < to_slot && s < csra_pkg::SLOT_DEPTH; s++)
        begin
            if (slot_mirror[s] == csra_pkg::SLOT_CLEAR)
            begin
                run_len++;
                if (run_len >= need)
                    return s;
            end
            else
            begin
                run_len = 0;
            end
        end
        return -1;
    endfunction

    // Applies one request to the mirror and returns the response it must cause.
    function automatic csra_pkg::csra_out_t apply_request(input csra_pkg::csra_in_t req);
        csra_pkg::csra_out_t rsp;
        int        need;
        int        wrap_end;
        int        first_from;
        int        second_to;
        int        guard_slot;
        int        s;
        logic      hit_guard;
        rsp = '0;
        if (req.func == csra_pkg::FUNC_ALLOC)
        begin
            // The run needs one extra clear slot for its guard.
            need       = int'(req.run_length) + 1;
            wrap_end   = (csra_pkg::DEF_SEARCH_ORIGIN / csra_pkg::DEF_SLOTS_PER_GROUP + 1)
                         * csra_pkg::DEF_SLOTS_PER_GROUP;
            first_from = (csra_pkg::DEF_SEARCH_ORIGIN + 1 < TABLE_SLOTS) ?
                         csra_pkg::DEF_SEARCH_ORIGIN + 1 : TABLE_SLOTS;
            second_to  = (wrap_end < TABLE_SLOTS) ? wrap_end : TABLE_SLOTS;
            // First scan starts after the origin; the wrapped scan restarts its
            // count at slot 0 and ends with the origin's group.
            guard_slot = last_of_clear_run(first_from, TABLE_SLOTS, need);
            if (guard_slot < 0)
                guard_slot = last_of_clear_run(0, second_to, need);
            if (guard_slot >= 0)
            begin
                for (s = guard_slot - int'(req.run_length); s < guard_slot; s++)
                    slot_mirror[s] = csra_pkg::SLOT_MAPPED;
                slot_mirror[guard_slot] = csra_pkg::SLOT_GUARD;
                rsp.ok          = 1'b1;
                rsp.result_slot = csra_pkg::SLOT_AW'(guard_slot - int'(req.run_length));
            end
        end
        else
        begin
            // The free walk clears everything it passes and stops after the
            // first guard, or at the end of the table without one.
            s = int'(req.start_slot);
            while (s < TABLE_SLOTS)
            begin
                hit_guard      = (slot_mirror[s] == csra_pkg::SLOT_GUARD);
                slot_mirror[s] = csra_pkg::SLOT_CLEAR;
                rsp.freed_count = rsp.freed_count + 1'b1;
                if (hit_guard)
                begin
                    rsp.ok = 1'b1;
                    break;
                end
                s++;
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request, waits for its transfer, records the response it
    // must cause, then possibly inserts an idle gap at the end of a burst.
    // Valid stays high between back-to-back requests.
    task automatic send_request(input logic func, input int run_len, input int start);
        csra_pkg::csra_in_t  req;
        csra_pkg::csra_out_t rsp;
        int        gap_cycles;
        req.func       = func;
        req.run_length = csra_pkg::SLOT_AW'(run_len);
        req.start_slot = csra_pkg::SLOT_AW'(start);
        request       <= req;
        request_valid <= 1'b1;
        do
            @(posedge clk);
        while (request_stall);

        rsp = apply_request(req);
        pending_responses.push_back(rsp);
        if (func == csra_pkg::FUNC_ALLOC && rsp.ok)
            live_runs.push_back(int'(rsp.result_slot));

        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            // Mostly short gaps, sometimes long ones, sometimes none at all.
            case ($urandom_range(0, 3))
                0: gap_cycles = 0;
                1: gap_cycles = $urandom_range(20, 60);
                default: gap_cycles = $urandom_range(1, 6);
            endcase
            if (gap_cycles > 0)
            begin
                request_valid <= 1'b0;
                repeat (gap_cycles) @(posedge clk);
            end
        end
    endtask

    // Holds the sender off until every owed response has been transferred.
    // It waits on the clock before it first checks the count.
    task automatic wait_for_responses();
        request_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A zero-length run takes a single clear slot, which becomes its guard.
    task automatic test_zero_length_runs();
        send_request(csra_pkg::FUNC_ALLOC, 0, $urandom_range(0, 4095));
        send_request(csra_pkg::FUNC_ALLOC, 0, $urandom_range(0, 4095));
        send_request(csra_pkg::FUNC_FREE, $urandom_range(0, 4095), 1);
        send_request(csra_pkg::FUNC_FREE, $urandom_range(0, 4095), 2);
        wait_for_responses();
    endtask

    // Requests that do not fit, a run filling every slot after the origin,
    // and the wrapped scan finding slot 0 once the rest is taken.
    task automatic test_full_table();
        send_request(csra_pkg::FUNC_ALLOC, 4095, 0);
        send_request(csra_pkg::FUNC_ALLOC, 4094, 4095);
        send_request(csra_pkg::FUNC_ALLOC, 0, 4095);
        send_request(csra_pkg::FUNC_ALLOC, 1, 0);
        send_request(csra_pkg::FUNC_FREE, 4095, 0);
        send_request(csra_pkg::FUNC_FREE, 0, 1);
        wait_for_responses();
    endtask

    // Free walks that run off the end without a guard, that start inside a
    // mapped run, and that cross mapped and clear slots alike.
    task automatic test_free_walks();
        send_request(csra_pkg::FUNC_FREE, 0, 4000);
        send_request(csra_pkg::FUNC_FREE, 4095, 4095);
        send_request(csra_pkg::FUNC_ALLOC, 2048, 0);
        send_request(csra_pkg::FUNC_ALLOC, 5, 4095);
        send_request(csra_pkg::FUNC_FREE, 2048, 2000);
        send_request(csra_pkg::FUNC_FREE, 5, 2050);
        send_request(csra_pkg::FUNC_FREE, 4095, 1);
        wait_for_responses();
    endtask

    // Alternating bit patterns on both slot fields.
    task automatic test_field_extremes();
        send_request(csra_pkg::FUNC_ALLOC, 'h555, 'hAAA);
        send_request(csra_pkg::FUNC_ALLOC, 'hAAA, 'h555);
        send_request(csra_pkg::FUNC_FREE, 'hAAA, 'h555);
        send_request(csra_pkg::FUNC_FREE, 'h555, 'hAAA);
        send_request(csra_pkg::FUNC_FREE, 0, 1);
        wait_for_responses();
    endtask

    // Mostly small allocations and frees of live runs, with some frees from
    // random slots and some large allocations mixed in.
    task automatic test_random_traffic(input int item_count);
        int i;
        int pick;
        int idx;
        int start;
        for (i = 0; i < item_count; i++)
        begin
            // Halfway through, let the block run completely dry once.
            if (i == item_count / 2)
                wait_for_responses();
            // Drop runs that some earlier free walk has already cleared.
            while (live_runs.size() > 0 &&
                   slot_mirror[live_runs[0]] == csra_pkg::SLOT_CLEAR)
                void'(live_runs.pop_front());
            pick = $urandom_range(0, 99);
            if (pick < 35 && live_runs.size() > 0)
            begin
                idx   = $urandom_range(0, live_runs.size() - 1);
                start = live_runs[idx];
                live_runs.delete(idx);
                send_request(csra_pkg::FUNC_FREE, $urandom_range(0, 4095), start);
            end
            else if (pick < 43)
            begin
                send_request(csra_pkg::FUNC_FREE, $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
            end
            else if (pick < 48)
            begin
                send_request(csra_pkg::FUNC_ALLOC, $urandom_range(256, 4095),
                             $urandom_range(0, 4095));
            end
            else
            begin
                send_request(csra_pkg::FUNC_ALLOC, $urandom_range(0, 24),
                             $urandom_range(0, 4095));
            end
        end
        wait_for_responses();
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // The receiver switches between free-flowing, randomly stalling and
    // solidly stalled stretches of random length.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
            stall_left <= $urandom_range(5, 60);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_RANDOM: response_stall <= 1'($urandom_range(0, 1));
            STALL_HOLD:   response_stall <= 1'b1;
            default:      response_stall <= 1'b0;
        endcase
    end

    // Every response transfer is matched against the oldest owed response.
    always @(posedge clk)
    begin
        csra_pkg::csra_out_t owed;
        if (rst_n && response_valid && !response_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with none owed: ok=%0d result_slot=%0d freed_count=%0d",
                         $time, response.ok, response.result_slot, response.freed_count);
                error_count++;
            end
            else
            begin
                owed = pending_responses.pop_front();
                if (response.ok !== owed.ok)
                begin
                    $display("%0t: ok expected %0d actual %0d", $time, owed.ok, response.ok);
                    error_count++;
                end
                if (response.result_slot !== owed.result_slot)
                begin
                    $display("%0t: result_slot expected %0d actual %0d",
                             $time, owed.result_slot, response.result_slot);
                    error_count++;
                end
                if (response.freed_count !== owed.freed_count)
                begin
                    $display("%0t: freed_count expected %0d actual %0d",
                             $time, owed.freed_count, response.freed_count);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (request_valid && !request_stall) || (response_valid && !response_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int s;
        for (s = 0; s < csra_pkg::SLOT_DEPTH; s++)
            slot_mirror[s] = csra_pkg::SLOT_CLEAR;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length_runs();
        test_full_table();
        test_free_walks();
        test_field_extremes();
        test_random_traffic(RANDOM_ITEMS);

        // Nothing is owed now; give a stray response time to show up.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ contiguous_slot_run_allocator.f @@
+incdir+hw/rtl
hw/rtl/csra_pkg.sv
hw/rtl/csra_slot_ram.sv
hw/rtl/contiguous_slot_run_allocator.sv
tb/contiguous_slot_run_allocator_tb.sv
